/* rtl/magic_header_record_deframer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the record deframer
// Shared property forms used by the checker of the deframer.
// ----------------------------------------------------------------------------
`ifndef MAGIC_HEADER_RECORD_DEFRAMER_UNIT_DEFINES_SVH
`define MAGIC_HEADER_RECORD_DEFRAMER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHRD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mhrd_pkg.sv */
// ----------------------------------------------------------------------------
// mhrd_pkg
// Types and constants shared by the record deframer modules.
// ----------------------------------------------------------------------------
package mhrd_pkg;

    localparam int unsigned HDR_BYTES = 16;

    localparam logic [31:0] REC_MAGIC   = 32'h4356_4d4c;
    localparam logic [15:0] REC_VERSION = 16'd1;
    localparam logic [15:0] REC_HSIZE   = 16'd16;
    localparam logic [7:0]  MARK_FF     = 8'hff;
    localparam logic [7:0]  MARK_SOI    = 8'hd8;
    localparam logic [7:0]  MARK_EOI    = 8'hd9;

    localparam logic [23:0] FRAME_SIZE_RESET = 24'd614400;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_FRAME_SIZE = 2'd1;

    // Operating modes; the fourth code behaves as H.264 records.
    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_MJPEG = 2'd1;

    typedef enum logic [1:0] {
        EV_PAYLOAD     = 2'd0,
        EV_HDR_REJECT  = 2'd1,
        EV_SIZE_REJECT = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  data_byte;
        logic [23:0] byte_offset;
        logic        frame_end;
        logic        frame_good;
    } result_t;

endpackage

/* rtl/mhrd_in_stage.sv */
// ----------------------------------------------------------------------------
// mhrd_in_stage
// Input register that holds one byte until the parser takes it.
// ----------------------------------------------------------------------------
module mhrd_in_stage
    import mhrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_data,
    input  logic       take,
    output item_t      item
);

    logic       valid_reg;
    logic [7:0] data_reg;

    assign in_ready = !valid_reg || take;
    assign item     = '{valid: valid_reg, data: data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

/* rtl/mhrd_core.sv */
// ----------------------------------------------------------------------------
// mhrd_core
// Header parser, payload counter and marker check, with the result register.
// ----------------------------------------------------------------------------
module mhrd_core
    import mhrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    output logic        take,
    input  logic [1:0]  mode,
    input  logic [23:0] frame_size,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_res
);

    logic [7:0]  win_reg [HDR_BYTES];
    logic [7:0]  win_next [HDR_BYTES];
    logic [7:0]  win_cur [HDR_BYTES];
    logic [4:0]  fill_reg, fill_next;
    logic [23:0] count_reg, count_next;
    logic [23:0] length_reg, length_next;
    logic [15:0] lead_reg, lead_next;
    logic [15:0] trail_reg, trail_next;
    logic        out_valid_reg;
    result_t     out_res_reg;

    logic        res_valid;
    result_t     res;
    logic [24:0] count_inc;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] hsize;
    logic [31:0] psize;
    logic        hdr_bad;
    logic        size_bad;
    logic        is_last;
    logic        marks_ok;

    assign take      = item.valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign count_inc = {1'b0, count_reg} + 25'd1;

    // Window with the incoming byte written at the fill position.
    always_comb
    begin
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            win_cur[i] = (fill_reg[3:0] == 4'(i)) ? item.data : win_reg[i];
        end
        magic    = {win_cur[3], win_cur[2], win_cur[1], win_cur[0]};
        version  = {win_cur[5], win_cur[4]};
        hsize    = {win_cur[7], win_cur[6]};
        psize    = {win_cur[11], win_cur[10], win_cur[9], win_cur[8]};
        hdr_bad  = (magic != REC_MAGIC) || (version != REC_VERSION) || (hsize != REC_HSIZE);
        size_bad = (psize == 32'd0) || (psize > {8'd0, frame_size});
    end

    always_comb
    begin
        win_next    = win_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        length_next = length_reg;
        lead_next   = lead_reg;
        trail_next  = trail_reg;
        res_valid   = 1'b0;
        res         = '{kind: EV_PAYLOAD, data_byte: 8'd0, byte_offset: 24'd0,
                        frame_end: 1'b0, frame_good: 1'b0};
        is_last     = 1'b0;
        marks_ok    = 1'b1;

        if (take)
        begin
            if (mode == MODE_RAW)
            begin
                is_last         = count_inc >= {1'b0, frame_size};
                count_next      = is_last ? 24'd0 : count_inc[23:0];
                res_valid       = 1'b1;
                res.data_byte   = item.data;
                res.byte_offset = count_reg;
                res.frame_end   = is_last;
                res.frame_good  = is_last;
            end
            else if (!fill_reg[4])
            begin
                if (fill_reg != 5'(HDR_BYTES - 1))
                begin
                    win_next  = win_cur;
                    fill_next = fill_reg + 5'd1;
                end
                else if (hdr_bad)
                begin
                    // Drop the oldest byte and wait for one more.
                    for (int i = 0; i < HDR_BYTES; i++)
                    begin
                        win_next[i] = (i < HDR_BYTES - 1) ? win_cur[(i + 1) % HDR_BYTES] : 8'd0;
                    end
                    fill_next   = 5'(HDR_BYTES - 1);
                    count_next  = 24'd0;
                    length_next = 24'd0;
                    res_valid   = 1'b1;
                    res.kind    = EV_HDR_REJECT;
                end
                else if (size_bad)
                begin
                    for (int i = 0; i < HDR_BYTES; i++)
                    begin
                        win_next[i] = 8'd0;
                    end
                    fill_next   = 5'd0;
                    count_next  = 24'd0;
                    length_next = 24'd0;
                    res_valid   = 1'b1;
                    res.kind    = EV_SIZE_REJECT;
                end
                else
                begin
                    win_next    = win_cur;
                    fill_next   = 5'(HDR_BYTES);
                    length_next = psize[23:0];
                    count_next  = 24'd0;
                    lead_next   = 16'd0;
                    trail_next  = 16'd0;
                end
            end
            else
            begin
                if (count_reg < 24'd2)
                begin
                    lead_next = {lead_reg[7:0], item.data};
                end
                trail_next      = {trail_reg[7:0], item.data};
                is_last         = count_inc >= {1'b0, length_reg};
                res_valid       = 1'b1;
                res.data_byte   = item.data;
                res.byte_offset = count_reg;
                if (!is_last)
                begin
                    count_next = count_inc[23:0];
                end
                else
                begin
                    if (mode == MODE_MJPEG)
                    begin
                        marks_ok = (length_reg >= 24'd4)
                                && (lead_next == {MARK_FF, MARK_SOI})
                                && (trail_next == {MARK_FF, MARK_EOI});
                    end
                    if (marks_ok)
                    begin
                        for (int i = 0; i < HDR_BYTES; i++)
                        begin
                            win_next[i] = 8'd0;
                        end
                        fill_next = 5'd0;
                    end
                    else
                    begin
                        // Resync from the accepted header shifted by one byte.
                        for (int i = 0; i < HDR_BYTES; i++)
                        begin
                            win_next[i] = (i < HDR_BYTES - 1) ? win_reg[(i + 1) % HDR_BYTES] : 8'd0;
                        end
                        fill_next = 5'(HDR_BYTES - 1);
                    end
                    count_next     = 24'd0;
                    length_next    = 24'd0;
                    res.frame_end  = 1'b1;
                    res.frame_good = marks_ok;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                win_reg[i] <= 8'd0;
            end
            fill_reg      <= 5'd0;
            count_reg     <= 24'd0;
            length_reg    <= 24'd0;
            lead_reg      <= 16'd0;
            trail_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg    <= win_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            lead_reg   <= lead_next;
            trail_reg  <= trail_next;
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

endmodule

/* rtl/magic_header_record_deframer_unit.sv */
// A byte accepted into the input register has its result item at the output once the parser
// has registered it (first the input register, then the parser's result register).
// Throughput: one byte per cycle while the output is not stalled; parser state updates once per byte.
// While a result waits in the output register, the input register can still take one byte.
// Reset (rst_n low, asynchronous) clears the header window, counters and both
// valid flags, and sets mode to raw and frame_size to 614400.
// ----------------------------------------------------------------------------
// magic_header_record_deframer_unit
// Byte stream deframer for raw frames and length-prefixed records.
// ----------------------------------------------------------------------------
module magic_header_record_deframer_unit
    import mhrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [31:8] byte_offset
    output logic [2:0]  m_axis_tuser,   // [1:0] event_kind, [2] frame_good
    output logic        m_axis_tlast,   // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    logic [1:0]  mode_reg;
    logic [23:0] frame_size_reg;
    item_t       item;
    logic        take;
    result_t     res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_RAW;
            frame_size_reg <= FRAME_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MODE)
            begin
                mode_reg <= cfg_data[1:0];
            end
            else if (cfg_index == REG_FRAME_SIZE)
            begin
                frame_size_reg <= cfg_data;
            end
        end
    end

    mhrd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .take     (take),
        .item     (item)
    );

    mhrd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .take       (take),
        .mode       (mode_reg),
        .frame_size (frame_size_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    assign m_axis_tdata = {res.byte_offset, res.data_byte};
    assign m_axis_tuser = {res.frame_good, res.kind};
    assign m_axis_tlast = res.frame_end;

endmodule

/* rtl/mhrd_checker.sv */
// ----------------------------------------------------------------------------
// mhrd_checker
// Port-level checks of the deframer output, bound to the top level.
// ----------------------------------------------------------------------------
`include "magic_header_record_deframer_unit_defines.svh"

module mhrd_checker
    import mhrd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,   // [7:0] data_byte, [31:8] byte_offset
    input logic [2:0]  m_axis_tuser,   // [1:0] event_kind, [2] frame_good
    input logic        m_axis_tlast    // frame_end
);

    logic out_stall;
    logic is_reject;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign is_reject = (m_axis_tuser[1:0] == EV_HDR_REJECT)
                    || (m_axis_tuser[1:0] == EV_SIZE_REJECT);

    // A stalled result stays put.
    `MHRD_ASSERT_NEXT(a_out_hold, out_stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
        && $stable(m_axis_tlast), "stalled result changed")

    // Rejection events carry no byte, no offset and no frame end.
    `MHRD_ASSERT_SAME(a_reject_clean, m_axis_tvalid && is_reject,
        (m_axis_tdata == 32'd0) && !m_axis_tlast && !m_axis_tuser[2],
        "rejection event with payload fields set")

    // A good frame flag only appears on the closing payload byte.
    `MHRD_ASSERT_SAME(a_good_at_end, m_axis_tvalid && m_axis_tuser[2],
        m_axis_tlast && (m_axis_tuser[1:0] == EV_PAYLOAD),
        "frame_good outside a frame end")

endmodule

bind magic_header_record_deframer_unit mhrd_checker u_mhrd_checker (.*);

/* tb/magic_header_record_deframer_unit_tb.sv */
// ----------------------------------------------------------------------------
// magic_header_record_deframer_unit_tb
// Self-checking bench for the record deframer. A byte source with bursty
// timing feeds raw, MJPEG and H.264 traffic built from well-formed records,
// corrupted headers, size rejects and noise. A stalling sink takes the
// results, and each one is checked against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
module magic_header_record_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mhrd_pkg::*;

    localparam logic [1:0] MODE_H264 = 2'd2;
    localparam logic [1:0] MODE_ALT  = 2'd3;   // unused code, decodes as H.264
    localparam logic [1:0] REG_SPARE = 2'd3;   // no register behind this index
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned PHASE_ITEMS = 110;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [23:0] cfg_data = 24'd0;

    // Parser model state.
    logic [1:0]  cur_mode;
    logic [23:0] cur_frame_size;
    logic [7:0]  hdr_win [HDR_BYTES];
    int unsigned hdr_fill;
    logic [23:0] run_count;
    logic [23:0] rec_length;
    logic [15:0] lead_pair;
    logic [15:0] trail_pair;

    logic [7:0]  pending_bytes [$];
    result_t     expected_events [$];
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    bit          in_taken = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned sink_left = 0;
    int unsigned sink_style = 0;
    int unsigned sink_phase = 0;

    magic_header_record_deframer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void clear_parser();
        foreach (hdr_win[i])
        begin
            hdr_win[i] = 8'h00;
        end
        hdr_fill = 0;
        run_count = 24'd0;
        rec_length = 24'd0;
    endfunction

    // Drop the oldest header byte and wait for one more.
    function automatic void slide_header();
        for (int i = 0; i < HDR_BYTES - 1; i++)
        begin
            hdr_win[i] = hdr_win[i + 1];
        end
        hdr_win[HDR_BYTES - 1] = 8'h00;
        hdr_fill = HDR_BYTES - 1;
        run_count = 24'd0;
        rec_length = 24'd0;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        logic [23:0] off;
        logic [31:0] magic;
        logic [31:0] psize;
        logic [15:0] ver;
        logic [15:0] hsz;
        bit          closes;
        bit          ok;
        r.kind = EV_PAYLOAD;
        r.data_byte = 8'h00;
        r.byte_offset = 24'd0;
        r.frame_end = 1'b0;
        r.frame_good = 1'b0;
        if (cur_mode == MODE_RAW)
        begin
            off = run_count;
            closes = ({8'h00, off} + 32'd1) >= {8'h00, cur_frame_size};
            run_count = closes ? 24'd0 : off + 24'd1;
            r.data_byte = b;
            r.byte_offset = off;
            r.frame_end = closes;
            r.frame_good = closes;
            return 1'b1;
        end
        if (hdr_fill < HDR_BYTES)
        begin
            hdr_win[hdr_fill] = b;
            hdr_fill++;
            if (hdr_fill < HDR_BYTES)
                return 1'b0;
            magic = {hdr_win[3], hdr_win[2], hdr_win[1], hdr_win[0]};
            ver   = {hdr_win[5], hdr_win[4]};
            hsz   = {hdr_win[7], hdr_win[6]};
            psize = {hdr_win[11], hdr_win[10], hdr_win[9], hdr_win[8]};
            if (magic != REC_MAGIC || ver != REC_VERSION || hsz != REC_HSIZE)
            begin
                slide_header();
                r.kind = EV_HDR_REJECT;
                return 1'b1;
            end
            if (psize == 32'd0 || psize > {8'h00, cur_frame_size})
            begin
                clear_parser();
                r.kind = EV_SIZE_REJECT;
                return 1'b1;
            end
            rec_length = psize[23:0];
            run_count = 24'd0;
            lead_pair = 16'h0000;
            trail_pair = 16'h0000;
            return 1'b0;
        end
        off = run_count;
        if (off < 24'd2)
            lead_pair = {lead_pair[7:0], b};
        trail_pair = {trail_pair[7:0], b};
        closes = ({8'h00, off} + 32'd1) >= {8'h00, rec_length};
        r.data_byte = b;
        r.byte_offset = off;
        if (!closes)
        begin
            run_count = off + 24'd1;
            return 1'b1;
        end
        ok = 1'b1;
        if (cur_mode == MODE_MJPEG)
            ok = rec_length >= 24'd4 && lead_pair == {MARK_FF, MARK_SOI}
                 && trail_pair == {MARK_FF, MARK_EOI};
        if (ok)
            clear_parser();
        else
            slide_header();
        r.frame_end = 1'b1;
        r.frame_good = ok;
        return 1'b1;
    endfunction

    function automatic void report_field(input string name, input logic [23:0] want,
                                         input logic [23:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Byte source: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin : byte_source
        logic       nv;
        logic [7:0] nd;
        nv = s_axis_tvalid;
        nd = s_axis_tdata;
        if (!rst_n)
            nv = 1'b0;
        else
        begin
            if (s_axis_tvalid && in_taken)
                nv = 1'b0;
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_bytes.size() > 0)
                begin
                    nd = pending_bytes.pop_front();
                    nv = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata <= nd;
    end

    // Result sink: the stall pattern switches between styles now and then.
    always @(negedge clk)
    begin : result_sink
        logic rdy;
        if (sink_left == 0)
        begin
            sink_style = $urandom_range(0, 3);
            sink_left = $urandom_range(32, 200);
        end
        else
            sink_left--;
        sink_phase++;
        case (sink_style)
            0: rdy = 1'b1;
            1: rdy = $urandom_range(0, 1);
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = (sink_phase % 5) < 3;
        endcase
        m_axis_tready <= rdy;
    end

    always @(posedge clk)
    begin : observe
        result_t want;
        result_t got;
        result_t pred;
        bit      moved;
        if (rst_n)
        begin
            in_taken = s_axis_tvalid && s_axis_tready;
            moved = in_taken;
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                if (cfg_index == REG_MODE)
                    cur_mode = cfg_data[1:0];
                else if (cfg_index == REG_FRAME_SIZE)
                    cur_frame_size = cfg_data;
            end
            // A result always trails its byte, so check before predicting.
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                got.kind = event_kind_t'(m_axis_tuser[1:0]);
                got.frame_good = m_axis_tuser[2];
                got.data_byte = m_axis_tdata[7:0];
                got.byte_offset = m_axis_tdata[31:8];
                got.frame_end = m_axis_tlast;
                if (expected_events.size() == 0)
                begin
                    error_count++;
                    $display("%0t: expected no result, actual kind %0d data %0h offset %0h",
                             $time, got.kind, got.data_byte, got.byte_offset);
                end
                else
                begin
                    want = expected_events.pop_front();
                    report_field("event_kind", 24'(want.kind), 24'(got.kind));
                    report_field("data_byte", 24'(want.data_byte), 24'(got.data_byte));
                    report_field("byte_offset", want.byte_offset, got.byte_offset);
                    report_field("frame_end", 24'(want.frame_end), 24'(got.frame_end));
                    report_field("frame_good", 24'(want.frame_good), 24'(got.frame_good));
                end
            end
            if (in_taken && deframe_byte(s_axis_tdata, pred))
                expected_events.push_back(pred);
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold off until every byte is in and every result is out, then let the
    // last header byte (which gives no result) settle inside the block.
    task automatic drain_and_settle();
        @(negedge clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // bad_pos >= 0 flips one bit in that byte of the fixed header fields.
    task automatic push_header(input logic [31:0] psize, input int bad_pos);
        logic [7:0] h [HDR_BYTES];
        h[0] = REC_MAGIC[7:0];
        h[1] = REC_MAGIC[15:8];
        h[2] = REC_MAGIC[23:16];
        h[3] = REC_MAGIC[31:24];
        h[4] = REC_VERSION[7:0];
        h[5] = REC_VERSION[15:8];
        h[6] = REC_HSIZE[7:0];
        h[7] = REC_HSIZE[15:8];
        for (int i = 0; i < 4; i++)
        begin
            h[8 + i] = psize[8 * i +: 8];
            h[12 + i] = 8'($urandom);
        end
        if (bad_pos >= 0)
            h[bad_pos] = h[bad_pos] ^ (8'h01 << $urandom_range(0, 7));
        foreach (h[i])
        begin
            pending_bytes.push_back(h[i]);
        end
    endtask

    task automatic push_record(input logic [1:0] m, input logic [23:0] fsize);
        int unsigned pick;
        int unsigned cap;
        logic [31:0] psize;
        logic [7:0]  b;
        bit          markers;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom));
        end
        else if (pick < 20)
        begin
            push_header($urandom_range(1, 8), $urandom_range(0, 7));
            repeat ($urandom_range(0, 4)) pending_bytes.push_back(8'($urandom));
        end
        else if (pick < 28)
        begin
            case ($urandom_range(0, 2))
                0: psize = 32'd0;
                1: psize = {8'h00, fsize} + 32'd1;
                default: psize = {8'($urandom_range(1, 255)), 24'($urandom)};
            endcase
            push_header(psize, -1);
        end
        else
        begin
            cap = (fsize < 24'd24) ? fsize : 24;
            if (cap == 0)
                psize = $urandom_range(1, 8);
            else if (pick >= 95 && fsize >= 24'd60)
                psize = $urandom_range(25, 60);
            else
                psize = $urandom_range(1, cap);
            push_header(psize, -1);
            markers = (m == MODE_MJPEG) && ($urandom_range(0, 3) != 0);
            for (int unsigned n = 0; n < psize; n++)
            begin
                b = 8'($urandom);
                if (markers)
                begin
                    if (n == 0 || n == psize - 2)
                        b = MARK_FF;
                    else if (n == 1)
                        b = MARK_SOI;
                    else if (n == psize - 1)
                        b = MARK_EOI;
                end
                pending_bytes.push_back(b);
            end
        end
    endtask

    initial
    begin
        logic [1:0]  m;
        logic [23:0] fs;
        int unsigned target;
        cur_mode = MODE_RAW;
        cur_frame_size = FRAME_SIZE_RESET;
        clear_parser();
        lead_pair = 16'h0000;
        trail_pair = 16'h0000;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Raw bytes under the reset settings.
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hff);
        pending_bytes.push_back(8'h0f);
        pending_bytes.push_back(8'hf0);
        drain_and_settle();
        // Frame size below the running count: the next byte closes the frame.
        write_reg(REG_FRAME_SIZE, 24'd2);
        pending_bytes.push_back(8'h5a);
        pending_bytes.push_back(8'ha5);
        pending_bytes.push_back(8'h01);
        drain_and_settle();
        // Smallest MJPEG record that passes the marker check.
        write_reg(REG_MODE, MODE_MJPEG);
        write_reg(REG_FRAME_SIZE, 24'd4);
        push_header(32'd4, -1);
        pending_bytes.push_back(MARK_FF);
        pending_bytes.push_back(MARK_SOI);
        pending_bytes.push_back(MARK_FF);
        pending_bytes.push_back(MARK_EOI);
        drain_and_settle();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: begin m = MODE_RAW; fs = 24'd0; end
                1: begin m = MODE_RAW; fs = 24'hffffff; end
                2: begin m = MODE_MJPEG; fs = $urandom_range(8, 40); end
                3: begin m = MODE_MJPEG; fs = 24'd0; end
                4: begin m = MODE_H264; fs = $urandom_range(1, 30); end
                5: begin m = MODE_RAW; fs = $urandom_range(3, 40); end
                6: begin m = MODE_ALT; fs = 24'hffffff; end
                7: begin m = MODE_MJPEG; fs = 24'hffffff; end
                8: begin m = MODE_H264; fs = 24'd1; end
                9: begin m = MODE_RAW; fs = 24'd1; end
                10: begin m = MODE_MJPEG; fs = 24'd4; end
                default: begin m = MODE_H264; fs = $urandom_range(5, 60); end
            endcase
            // Upper data bits of a mode write are don't-care.
            write_reg(REG_MODE, {22'($urandom), m});
            write_reg(REG_FRAME_SIZE, fs);
            if (ph == 4)
                write_reg(REG_SPARE, 24'($urandom));
            target = PHASE_ITEMS;
            while (pending_bytes.size() < target)
            begin
                if (m == MODE_RAW)
                    pending_bytes.push_back(8'($urandom));
                else
                    push_record(m, fs);
            end
            drain_and_settle();
        end

        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mhrd_pkg.sv
rtl/mhrd_in_stage.sv
rtl/mhrd_core.sv
rtl/magic_header_record_deframer_unit.sv
rtl/mhrd_checker.sv
tb/magic_header_record_deframer_unit_tb.sv
